// ===== src/hsg_pkg.sv =====
`default_nettype none
package hsg_pkg;
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_STEP   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] REG_DIFF  = 3'd0;
	localparam logic [2:0] REG_GEN   = 3'd1;
	localparam logic [2:0] REG_BND   = 3'd2;
	localparam logic [2:0] REG_FLUID = 3'd3;
	localparam logic [2:0] REG_WALL  = 3'd4;
	localparam logic [2:0] REG_NEAR  = 3'd5;
	localparam logic [2:0] REG_FAR   = 3'd6;
	localparam logic [2:0] REG_EDGES = 3'd7;

	// kinds of cell update in the sweep
	localparam logic [1:0] UPD_DIFF = 2'd0;
	localparam logic [1:0] UPD_NEAR = 2'd1;
	localparam logic [1:0] UPD_FAR  = 2'd2;
	localparam logic [1:0] UPD_SET  = 2'd3;

	typedef struct packed {
		logic [15:0] diff;
		logic signed [23:0] gen;
		logic signed [31:0] bnd;
		logic signed [31:0] fluid;
		logic signed [31:0] wall;
		logic signed [17:0] near;
		logic signed [17:0] far;
		logic edges;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic clr;       // clear the accumulator (to zero, or to the wall drive term)
		logic rd;        // read memory at addr
		logic acc;       // add weight * read data
		logic signed [3:0] wt;
		logic fin;       // form result
		logic [1:0] kind;
		logic wr;        // write result, host data, a constant or read data at waddr
		logic use_host;
		logic use_const; // write const_sel value instead of result
		logic const_sel; // 0 boundary, 1 fluid
		logic cap;       // capture read data as read_value
	} cmd_t;
endpackage
`default_nettype wire

// ===== src/hsg_datapath.sv =====
`default_nettype none
module hsg_datapath #(
	parameter int AW = 8
) (
	input  wire logic clk,
	input  wire hsg_pkg::cmd_t cmd,
	input  wire hsg_pkg::cfg_t cfg,
	input  wire logic [AW-1:0] raddr,
	input  wire logic [AW-1:0] waddr,
	input  wire logic signed [31:0] host_data,
	output logic signed [31:0] rd_value
);
	logic signed [31:0] mem [2**AW];
	logic signed [31:0] rdata_q;
	logic acc_s1;
	logic signed [3:0] wt_s1;
	logic signed [37:0] sum_q;
	logic signed [37:0] t_q;
	logic signed [55:0] prod_q;
	logic signed [31:0] res_q;
	logic signed [37:0] rd_ext;
	logic signed [17:0] gain;
	logic signed [56:0] rnd;
	logic signed [40:0] tot;
	logic signed [31:0] wval;

	assign rd_ext = 38'(rdata_q);

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_q <= mem[raddr];
		if (cmd.wr) mem[waddr] <= wval;
	end

	always_ff @(posedge clk) begin
		acc_s1 <= cmd.acc;
		wt_s1 <= cmd.wt;
		if (cmd.clr) begin
			// wall stencils start from the drive term
			sum_q <= (cmd.kind == hsg_pkg::UPD_DIFF) ? '0 : 38'(cfg.wall);
		end else if (acc_s1) begin
			sum_q <= sum_q + 38'(rd_ext * 38'(wt_s1));
			// in the diffusion stencil the center cell is read with weight -4
			if (wt_s1 == -4'sd4) t_q <= rd_ext;
		end
		if (cmd.cap) rd_value <= rdata_q;
	end

	always_comb begin
		case (cmd.kind)
			hsg_pkg::UPD_NEAR: gain = cfg.near;
			hsg_pkg::UPD_FAR:  gain = cfg.far;
			default:           gain = $signed({2'b00, cfg.diff});
		endcase
	end

	// multiply stage, then round and saturate
	always_ff @(posedge clk) begin
		prod_q <= 56'(sum_q * 56'(gain));
	end

	always_comb begin
		rnd = (57'(prod_q) + 57'sd32768) >>> 16;
		if (cmd.kind == hsg_pkg::UPD_DIFF)
			tot = 41'(rnd) + 41'(t_q) + 41'(cfg.gen);
		else
			tot = 41'(rnd);
		if (tot > 41'sd2147483647) res_q = 32'h7fffffff;
		else if (tot < -41'sd2147483648) res_q = 32'h80000000;
		else res_q = tot[31:0];
	end

	always_comb begin
		if (cmd.use_host) wval = host_data;
		else if (cmd.use_const) wval = cmd.const_sel ? cfg.fluid : cfg.bnd;
		else if (cmd.fin) wval = res_q;
		else wval = rdata_q;
	end
endmodule
`default_nettype wire

// ===== src/hsg_ctrl.sv =====
`default_nettype none
module hsg_ctrl #(
	parameter int N = 16,
	parameter int HS = 6,
	parameter int HE = 9,
	parameter int AW = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [3:0] row,
	input  wire logic [3:0] column,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] done_kind,
	output logic zero_q,
	input  wire logic edges,
	output hsg_pkg::cmd_t cmd,
	output logic [AW-1:0] raddr,
	output logic [AW-1:0] waddr
);
	localparam int CW = $clog2(N);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_OUT = 4'd3,
		S_BND = 4'd4, S_CPR = 4'd5, S_CPW1 = 4'd6, S_CPW = 4'd7, S_HOLE = 4'd8,
		S_TAP = 4'd9, S_MUL = 4'd10, S_RES = 4'd11, S_NEXT = 4'd12;

	logic [3:0] st_q;
	logic [1:0] op_q;
	logic [CW-1:0] i_q, j_q;
	logic [2:0] tap_q;
	logic [1:0] pass_q;  // boundary pass: 0 top, 3 right, 1 left, 2 bottom
	logic [1:0] kind_q;
	logic [AW-1:0] hw_addr;
	logic hw_ok;

	function automatic logic [CW-1:0] clp(input int k);
		if (k < 0) return '0;
		if (k > N - 1) return CW'(N - 1);
		return CW'(k);
	endfunction

	function automatic logic [AW-1:0] ad(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return AW'({r, c});
	endfunction

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign done_kind = op_q;
	assign hw_ok = (32'(row) < N) && (32'(column) < N);
	assign hw_addr = ad(CW'(row), CW'(column));

	// kind of update for cell (i,j)
	function automatic logic [1:0] kind_of(input logic [CW-1:0] i, input logic [CW-1:0] j);
		logic in_rows;
		in_rows = (int'(i) >= HS) && (int'(i) <= HE);
		if (int'(i) > HS && int'(i) < HE && int'(j) > HS && int'(j) < HE)
			return hsg_pkg::UPD_SET;
		if (int'(j) == HS + 1 && in_rows) return hsg_pkg::UPD_NEAR;
		if (int'(j) == HE - 1 && in_rows) return hsg_pkg::UPD_FAR;
		return hsg_pkg::UPD_DIFF;
	endfunction

	always_comb begin
		cmd = '0;
		cmd.kind = kind_q;
		raddr = '0;
		waddr = ad(i_q, j_q);
		case (st_q)
			S_IDLE: begin
				if (in_valid && operation == hsg_pkg::OP_WRITE && hw_ok) begin
					cmd.wr = 1'b1;
					cmd.use_host = 1'b1;
					waddr = hw_addr;
				end
				if (in_valid && operation == hsg_pkg::OP_READ && hw_ok) begin
					cmd.rd = 1'b1;
					raddr = hw_addr;
				end
			end
			S_RDW: cmd.cap = 1'b1;
			S_BND: begin
				cmd.wr = 1'b1;
				cmd.use_const = 1'b1;
				if (pass_q == 2'd0) waddr = ad('0, j_q);
				else waddr = ad(j_q, CW'(N - 1));
			end
			S_CPR: begin
				cmd.rd = 1'b1;
				if (pass_q == 2'd1) raddr = ad(j_q, CW'(1));
				else raddr = ad(CW'(N - 2), j_q);
			end
			S_CPW: begin
				cmd.wr = 1'b1;
				cmd.use_const = edges;
				if (pass_q == 2'd1) waddr = ad(j_q, '0);
				else waddr = ad(CW'(N - 1), j_q);
			end
			S_HOLE: begin
				cmd.wr = 1'b1;
				cmd.use_const = 1'b1;
				cmd.const_sel = 1'b1;
			end
			S_TAP: begin
				if (tap_q == 3'd0) cmd.clr = 1'b1;
				cmd.rd = 1'b1;
				cmd.acc = 1'b1;
				case (kind_q)
					hsg_pkg::UPD_NEAR: begin
						case (tap_q)
							3'd0: begin raddr = ad(i_q, clp(int'(j_q) - 1)); cmd.wt = 4'sd4; end
							default: begin raddr = ad(i_q, clp(int'(j_q) - 2)); cmd.wt = -4'sd1; end
						endcase
					end
					hsg_pkg::UPD_FAR: begin
						case (tap_q)
							3'd0: begin raddr = ad(i_q, clp(int'(j_q) + 1)); cmd.wt = -4'sd4; end
							default: begin raddr = ad(i_q, clp(int'(j_q) + 2)); cmd.wt = 4'sd1; end
						endcase
					end
					default: begin
						cmd.wt = 4'sd1;
						case (tap_q)
							3'd0: begin raddr = ad(i_q, j_q); cmd.wt = -4'sd4; end
							3'd1: raddr = ad(i_q + 1'b1, j_q);
							3'd2: raddr = ad(i_q - 1'b1, j_q);
							3'd3: raddr = ad(i_q, j_q + 1'b1);
							default: raddr = ad(i_q, j_q - 1'b1);
						endcase
					end
				endcase
			end
			S_NEXT: begin
				// last tap is in the sum, product lands in the multiply register
			end
			S_RES: begin
				cmd.fin = 1'b1;
				// cells inside the hollow square keep their value
				cmd.wr = (kind_q != hsg_pkg::UPD_SET);
			end
			default: ;
		endcase
	end

	logic [2:0] ntaps;
	assign ntaps = (kind_q == hsg_pkg::UPD_DIFF) ? 3'd5 : 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			op_q <= '0;
			i_q <= '0;
			j_q <= '0;
			tap_q <= '0;
			pass_q <= '0;
			kind_q <= '0;
			zero_q <= 1'b1;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					op_q <= operation;
					zero_q <= !(operation == hsg_pkg::OP_READ && hw_ok);
					if (operation == hsg_pkg::OP_READ && hw_ok) st_q <= S_RD;
					else if (operation == hsg_pkg::OP_STEP) begin
						st_q <= S_BND;
						pass_q <= 2'd0;
						j_q <= '0;
					end else st_q <= S_OUT;
				end
				S_RD: st_q <= S_RDW;
				S_RDW: st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				S_BND: begin
					if (pass_q == 2'd0) pass_q <= 2'd3;
					else if (j_q == CW'(N - 1)) begin
						j_q <= '0;
						pass_q <= 2'd1;
						st_q <= S_CPR;
					end else begin
						pass_q <= 2'd0;
						j_q <= j_q + 1'b1;
					end
				end
				S_CPR: st_q <= S_CPW1;
				S_CPW1: st_q <= S_CPW;
				S_CPW: begin
					if (pass_q == 2'd1) pass_q <= 2'd2;
					else begin
						pass_q <= 2'd1;
						if (j_q == CW'(N - 1)) begin
							if (HS < HE && HS < N) begin
								i_q <= CW'(HS);
								j_q <= CW'(HS);
								st_q <= S_HOLE;
							end else begin
								i_q <= CW'(1);
								j_q <= CW'(1);
								kind_q <= kind_of(CW'(1), CW'(1));
								tap_q <= '0;
								st_q <= S_TAP;
							end
						end else j_q <= j_q + 1'b1;
					end
					if (!(pass_q == 2'd2 && j_q == CW'(N - 1))) st_q <= S_CPR;
				end
				S_HOLE: begin
					if (int'(j_q) >= HE - 1 || int'(j_q) >= N - 1) begin
						if (int'(i_q) >= HE - 1 || int'(i_q) >= N - 1) begin
							i_q <= CW'(1);
							j_q <= CW'(1);
							kind_q <= kind_of(CW'(1), CW'(1));
							tap_q <= '0;
							st_q <= S_TAP;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= CW'(HS);
						end
					end else j_q <= j_q + 1'b1;
				end
				S_TAP: begin
					if (kind_q == hsg_pkg::UPD_SET) st_q <= S_RES;
					else if (tap_q == ntaps - 3'd1) begin
						tap_q <= '0;
						st_q <= S_MUL;
					end else tap_q <= tap_q + 1'b1;
				end
				S_MUL: st_q <= S_NEXT;
				S_NEXT: st_q <= S_RES;
				S_RES: begin
					if (j_q == CW'(N - 2)) begin
						if (i_q == CW'(N - 2)) st_q <= S_OUT;
						else begin
							i_q <= i_q + 1'b1;
							j_q <= CW'(1);
							kind_q <= kind_of(i_q + 1'b1, CW'(1));
							st_q <= S_TAP;
						end
					end else begin
						j_q <= j_q + 1'b1;
						kind_q <= kind_of(i_q, j_q + 1'b1);
						st_q <= S_TAP;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/heat_stencil_grid_step_unit.sv =====
// a read passes through S_RD and S_RDW before the answer; a time step sets the boundary,
// copies the edges, fills the hollow square and then sweeps the interior cells, where wall
// cells read fewer taps than diffusion cells and hollow cells skip the taps and multiply
// throughput: one item at a time; a step is set by the single memory read port,
// one neighbor tap per cycle plus multiply and writeback per cell
// reset: arst_n clears control and loads register defaults; grid is not cleared
`default_nettype none
module heat_stencil_grid_step_unit #(
	parameter int GRID_SIZE = 16,
	parameter int HOLE_START = 6,
	parameter int HOLE_END = 9
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [3:0] row,
	input  wire logic [3:0] column,
	input  wire logic signed [31:0] cell_value,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] read_value,
	output logic [1:0] done_kind,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int AW = 2 * $clog2(GRID_SIZE);
	hsg_pkg::cfg_t cfg_q, cfg_x;
	hsg_pkg::cmd_t cmd;
	logic [AW-1:0] raddr, waddr;
	logic signed [31:0] rd_value;
	logic zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff <= 16'd31130;
			cfg_q.gen <= 24'sd202667;
			cfg_q.bnd <= 32'sd6553600;
			cfg_q.fluid <= 32'sd1310720;
			cfg_q.wall <= 32'sd409600;
			cfg_q.near <= 18'sd19784;
			cfg_q.far <= -18'sd24385;
			cfg_q.edges <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hsg_pkg::REG_DIFF:  cfg_q.diff <= cfg_data[15:0];
				hsg_pkg::REG_GEN:   cfg_q.gen <= cfg_data[23:0];
				hsg_pkg::REG_BND:   cfg_q.bnd <= cfg_data;
				hsg_pkg::REG_FLUID: cfg_q.fluid <= cfg_data;
				hsg_pkg::REG_WALL:  cfg_q.wall <= cfg_data;
				hsg_pkg::REG_NEAR:  cfg_q.near <= cfg_data[17:0];
				hsg_pkg::REG_FAR:   cfg_q.far <= cfg_data[17:0];
				default:            cfg_q.edges <= cfg_data[0];
			endcase
		end
	end

	assign cfg_x = cfg_q;

	hsg_ctrl #(.N(GRID_SIZE), .HS(HOLE_START), .HE(HOLE_END), .AW(AW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .row, .column,
		.out_valid, .out_ready, .done_kind, .zero_q, .edges(cfg_q.edges),
		.cmd, .raddr, .waddr
	);

	hsg_datapath #(.AW(AW)) u_dp (
		.clk, .cmd, .cfg(cfg_x), .raddr, .waddr, .host_data(cell_value), .rd_value
	);

	assign read_value = zero_q ? 32'sd0 : rd_value;
endmodule
`default_nettype wire
